// ----- sv/mtbf_pkg.sv -----
// ----------------------------------------------------------------------------
// mtbf_pkg
// Shared types, widths and helpers for the multi-tube brightness fader.
// ----------------------------------------------------------------------------
package mtbf_pkg;

    // Array size and level width
    localparam int TUBE_COUNT  = 6;
    localparam int LEVEL_BITS  = 8;
    localparam int TUBE_W      = (TUBE_COUNT > 1) ? $clog2(TUBE_COUNT) : 1;

    // Fixed field widths
    localparam int STEPS_W     = 12;
    localparam int DELAY_W     = 16;
    localparam int INTERVAL_W  = 10;
    localparam int DUR_W       = 12;
    localparam int MULT_W      = 10;
    localparam int BASE_W      = 10;
    localparam int ORDER_W     = 24;
    localparam int POS_W       = 4;
    localparam int PROD_W      = POS_W + MULT_W;
    localparam int ORDER_TUBES = ORDER_W / POS_W;

    // Shared divider: dividend covers both the duration and a level difference
    localparam int DVD_W       = (LEVEL_BITS > DUR_W) ? LEVEL_BITS : DUR_W;
    localparam int DVS_W       = STEPS_W;
    localparam int DCNT_W      = $clog2(DVD_W + 1);

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(10);

    // Command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Pattern codes
    localparam logic [1:0] PAT_L2R   = 2'd0;
    localparam logic [1:0] PAT_R2L   = 2'd1;
    localparam logic [1:0] PAT_ORDER = 2'd2;

    // Per-tube fade parameters held in the parameter memory
    typedef struct packed {
        logic [LEVEL_BITS-1:0] target;
        logic [DELAY_W-1:0]    delay;
        logic [STEPS_W-1:0]    steps;
    } par_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SDIV,
        ST_SWR,
        ST_RD,
        ST_EVAL,
        ST_TDIV,
        ST_TWR,
        ST_ORD,
        ST_OUT
    } state_t;

    // Position of a tube within the chosen pattern
    function automatic logic [POS_W-1:0] position_of(
        input logic [TUBE_W-1:0]  tube,
        input logic [1:0]         pat,
        input logic [ORDER_W-1:0] order
    );
        logic [ORDER_W-1:0] sh;
        logic [POS_W-1:0]   pos;
        sh  = order >> {tube, 2'b00};
        pos = POS_W'(tube);
        case (pat)
            PAT_R2L:   pos = POS_W'(TUBE_COUNT - 1) - POS_W'(tube);
            PAT_ORDER: pos = (int'(tube) >= ORDER_TUBES) ? '0 : sh[POS_W-1:0];
            default:   pos = POS_W'(tube);
        endcase
        return pos;
    endfunction

endpackage

// ----- sv/multi_tube_brightness_fader_top.sv -----
// ----------------------------------------------------------------------------
// multi_tube_brightness_fader_top
// Per-tube brightness fade engine with a shared serial divider.
// ----------------------------------------------------------------------------
// A start word loads every tube with the target level, a step count of
// max(1, duration_ms / step_interval) and a start delay of base_delay plus
// its pattern position times delay_multiplier; it returns no result words.
// A tick word walks all tubes once, counting delays down and stepping tubes
// whose delay has run out, then returns one word per tube in tube order with
// the shared changed and all_done flags and last set on the final tube.
// State lives in two single-port-style memories (levels and fade parameters),
// each read through a registered output, and one restoring divider producing
// one quotient bit per cycle serves both the step-count division and the
// per-step level division. Items are handled one at a time: a start runs the
// step-count division and then writes each tube's parameters, and a tick
// reads, evaluates and, where due, divides and writes back each tube before
// emitting its result words. The next word is accepted while the last result
// word still waits in the output register.
module multi_tube_brightness_fader_top
    import mtbf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_we,
    input  logic [INTERVAL_W-1:0] cfg_wdata,
    // input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  cmd,
    input  logic [7:0]            target_level,
    input  logic [DUR_W-1:0]      duration_ms,
    input  logic [1:0]            pattern,
    input  logic [MULT_W-1:0]     delay_multiplier,
    input  logic [BASE_W-1:0]     base_delay,
    input  logic [ORDER_W-1:0]    tube_order,
    // output channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [3:0]            tube_number,
    output logic [7:0]            level,
    output logic                  changed,
    output logic                  all_done,
    output logic                  last
);

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    state_t                  state_reg, state_next;
    logic [TUBE_W-1:0]       idx_reg, idx_next;
    logic                    upd_reg, upd_next;
    logic                    done_reg, done_next;
    logic [INTERVAL_W-1:0]   interval_reg;
    logic [INTERVAL_W-1:0]   eff_int;
    logic [STEPS_W-1:0]      step_cnt_reg, step_cnt_next;

    // latched start fields
    logic [LEVEL_BITS-1:0]   tgt_reg;
    logic [1:0]              pat_reg;
    logic [MULT_W-1:0]       mult_reg;
    logic [BASE_W-1:0]       base_reg;
    logic [ORDER_W-1:0]      order_reg;

    // divider
    logic [DVD_W-1:0]        div_quo_reg, div_quo_next;
    logic [DVS_W-1:0]        div_rem_reg, div_rem_next;
    logic [DVS_W-1:0]        div_dvs_reg, div_dvs_next;
    logic [DCNT_W-1:0]       div_cnt_reg, div_cnt_next;
    logic [DVS_W:0]          div_sh;
    logic [DVS_W:0]          div_sub;
    logic                    div_ge;

    // memories
    logic [LEVEL_BITS-1:0]   lvl_mem [TUBE_COUNT];
    par_t                    par_mem [TUBE_COUNT];
    logic [TUBE_COUNT-1:0]   lvl_vld_reg;
    logic [TUBE_COUNT-1:0]   par_vld_reg;
    logic [LEVEL_BITS-1:0]   lvl_rd_reg;
    par_t                    par_rd_reg;
    logic                    lvl_rd_vld_reg;
    logic                    par_rd_vld_reg;
    logic                    rd_en;
    logic                    lvl_we;
    logic                    par_we;
    logic [LEVEL_BITS-1:0]   lvl_wdata;
    par_t                    par_wdata;
    logic [LEVEL_BITS-1:0]   lvl_cur;
    par_t                    par_cur;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic [3:0]              out_tube_reg, out_tube_next;
    logic [7:0]              out_level_reg, out_level_next;
    logic                    out_changed_reg, out_changed_next;
    logic                    out_done_reg, out_done_next;
    logic                    out_last_reg, out_last_next;

    // helpers
    logic                    idx_last;
    logic                    in_acc;
    logic [POS_W-1:0]        pos_w;
    logic [PROD_W-1:0]       dly_prod;
    logic                    tgt_ge;
    logic [LEVEL_BITS-1:0]   mag;
    logic [LEVEL_BITS-1:0]   new_lvl;
    logic [STEPS_W-1:0]      steps_dec;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            interval_reg <= cfg_wdata;
        end
    end

    // Treat a zero interval as one
    assign eff_int = (interval_reg == '0) ? INTERVAL_W'(1) : interval_reg;

    // ------------------------------------------------------------------
    // Shared helpers
    // ------------------------------------------------------------------
    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign idx_last = (idx_reg == TUBE_W'(TUBE_COUNT - 1));

    // Unwritten entries read as the reset value
    assign lvl_cur = lvl_rd_vld_reg ? lvl_rd_reg : '0;
    assign par_cur = par_rd_vld_reg ? par_rd_reg : '0;

    // Start delay for the tube being written
    assign pos_w    = position_of(idx_reg, pat_reg, order_reg);
    assign dly_prod = PROD_W'(pos_w) * PROD_W'(mult_reg);

    // Fade step: magnitude of the difference and the stepped level
    assign tgt_ge    = (par_cur.target >= lvl_cur);
    assign mag       = tgt_ge ? (par_cur.target - lvl_cur) : (lvl_cur - par_cur.target);
    assign new_lvl   = tgt_ge ? (lvl_cur + div_quo_reg[LEVEL_BITS-1:0])
                              : (lvl_cur - div_quo_reg[LEVEL_BITS-1:0]);
    assign steps_dec = par_cur.steps - STEPS_W'(1);

    // One restoring divider step
    assign div_sh  = {div_rem_reg, div_quo_reg[DVD_W-1]};
    assign div_ge  = (div_sh >= {1'b0, div_dvs_reg});
    assign div_sub = div_sh - {1'b0, div_dvs_reg};

    // ------------------------------------------------------------------
    // State register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Next state and datapath control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        upd_next         = upd_reg;
        done_next        = done_reg;
        step_cnt_next    = step_cnt_reg;
        div_quo_next     = div_quo_reg;
        div_rem_next     = div_rem_reg;
        div_dvs_next     = div_dvs_reg;
        div_cnt_next     = div_cnt_reg;
        rd_en            = 1'b0;
        lvl_we           = 1'b0;
        par_we           = 1'b0;
        lvl_wdata        = new_lvl;
        par_wdata        = par_cur;
        out_valid_next   = out_valid_reg;
        out_tube_next    = out_tube_reg;
        out_level_next   = out_level_reg;
        out_changed_next = out_changed_reg;
        out_done_next    = out_done_reg;
        out_last_next    = out_last_reg;

        // drop the output word once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    idx_next = '0;
                    if (cmd == CMD_START)
                    begin
                        div_quo_next = DVD_W'(duration_ms);
                        div_rem_next = '0;
                        div_dvs_next = DVS_W'(eff_int);
                        div_cnt_next = DCNT_W'(DVD_W);
                        state_next   = ST_SDIV;
                    end
                    else
                    begin
                        upd_next   = 1'b0;
                        done_next  = 1'b1;
                        state_next = ST_RD;
                    end
                end
            end

            // step count = duration / interval, at least one
            ST_SDIV:
            begin
                if (div_cnt_reg != '0)
                begin
                    div_rem_next = div_ge ? div_sub[DVS_W-1:0] : div_sh[DVS_W-1:0];
                    div_quo_next = {div_quo_reg[DVD_W-2:0], div_ge};
                    div_cnt_next = div_cnt_reg - DCNT_W'(1);
                end
                else
                begin
                    step_cnt_next = (div_quo_reg == '0) ? STEPS_W'(1)
                                                        : div_quo_reg[STEPS_W-1:0];
                    state_next    = ST_SWR;
                end
            end

            // load every tube's fade parameters
            ST_SWR:
            begin
                par_we           = 1'b1;
                par_wdata.target = tgt_reg;
                par_wdata.delay  = DELAY_W'(base_reg) + DELAY_W'(dly_prod);
                par_wdata.steps  = step_cnt_reg;
                if (idx_last)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + TUBE_W'(1);
                end
            end

            ST_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_EVAL;
            end

            ST_EVAL:
            begin
                if (par_cur.steps == '0)
                begin
                    if (idx_last)
                    begin
                        idx_next   = '0;
                        state_next = ST_ORD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + TUBE_W'(1);
                        state_next = ST_RD;
                    end
                end
                else if (par_cur.delay != '0)
                begin
                    // count the delay down
                    par_we          = 1'b1;
                    par_wdata.delay = par_cur.delay - DELAY_W'(1);
                    done_next       = 1'b0;
                    if (idx_last)
                    begin
                        idx_next   = '0;
                        state_next = ST_ORD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + TUBE_W'(1);
                        state_next = ST_RD;
                    end
                end
                else
                begin
                    div_quo_next = DVD_W'(mag);
                    div_rem_next = '0;
                    div_dvs_next = par_cur.steps;
                    div_cnt_next = DCNT_W'(DVD_W);
                    state_next   = ST_TDIV;
                end
            end

            // delta = |target - level| / steps_left
            ST_TDIV:
            begin
                if (div_cnt_reg != '0)
                begin
                    div_rem_next = div_ge ? div_sub[DVS_W-1:0] : div_sh[DVS_W-1:0];
                    div_quo_next = {div_quo_reg[DVD_W-2:0], div_ge};
                    div_cnt_next = div_cnt_reg - DCNT_W'(1);
                end
                else
                begin
                    state_next = ST_TWR;
                end
            end

            // write back the stepped level and parameters
            ST_TWR:
            begin
                lvl_we          = 1'b1;
                lvl_wdata       = new_lvl;
                par_we          = 1'b1;
                par_wdata.steps = steps_dec;
                if (steps_dec != '0)
                begin
                    par_wdata.delay = DELAY_W'(eff_int);
                    done_next       = 1'b0;
                end
                upd_next = 1'b1;
                if (idx_last)
                begin
                    idx_next   = '0;
                    state_next = ST_ORD;
                end
                else
                begin
                    idx_next   = idx_reg + TUBE_W'(1);
                    state_next = ST_RD;
                end
            end

            ST_ORD:
            begin
                rd_en      = 1'b1;
                state_next = ST_OUT;
            end

            // hold until the output register is free, then emit the word
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_tube_next    = 4'(idx_reg);
                    out_level_next   = 8'(lvl_cur);
                    out_changed_next = upd_reg;
                    out_done_next    = upd_reg && done_reg;
                    out_last_next    = idx_last;
                    if (idx_last)
                    begin
                        idx_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + TUBE_W'(1);
                        state_next = ST_ORD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            upd_reg       <= 1'b0;
            done_reg      <= 1'b1;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            lvl_vld_reg   <= '0;
            par_vld_reg   <= '0;
        end
        else
        begin
            idx_reg       <= idx_next;
            upd_reg       <= upd_next;
            done_reg      <= done_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
            if (lvl_we)
            begin
                lvl_vld_reg[idx_reg] <= 1'b1;
            end
            if (par_we)
            begin
                par_vld_reg[idx_reg] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        step_cnt_reg    <= step_cnt_next;
        div_quo_reg     <= div_quo_next;
        div_rem_reg     <= div_rem_next;
        div_dvs_reg     <= div_dvs_next;
        out_tube_reg    <= out_tube_next;
        out_level_reg   <= out_level_next;
        out_changed_reg <= out_changed_next;
        out_done_reg    <= out_done_next;
        out_last_reg    <= out_last_next;
        if (in_acc)
        begin
            tgt_reg   <= LEVEL_BITS'(target_level);
            pat_reg   <= pattern;
            mult_reg  <= delay_multiplier;
            base_reg  <= base_delay;
            order_reg <= tube_order;
        end
    end

    // ------------------------------------------------------------------
    // Level and parameter memories
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (lvl_we)
        begin
            lvl_mem[idx_reg] <= lvl_wdata;
        end
        if (par_we)
        begin
            par_mem[idx_reg] <= par_wdata;
        end
        if (rd_en)
        begin
            lvl_rd_reg <= lvl_mem[idx_reg];
            par_rd_reg <= par_mem[idx_reg];
        end
    end

    // Sample entry valid bits alongside the read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_rd_vld_reg <= 1'b0;
            par_rd_vld_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            lvl_rd_vld_reg <= lvl_vld_reg[idx_reg];
            par_rd_vld_reg <= par_vld_reg[idx_reg];
        end
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign out_valid   = out_valid_reg;
    assign tube_number = out_tube_reg;
    assign level       = out_level_reg;
    assign changed     = out_changed_reg;
    assign all_done    = out_done_reg;
    assign last        = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    a_last_tube: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (tube_number == 4'(TUBE_COUNT - 1)))
        else $error("last flag on a word that is not the final tube");

    a_done_needs_change: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (changed || !all_done))
        else $error("all_done without a step in the tick");

    a_start_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWR) |-> (step_cnt_reg != '0))
        else $error("start loaded a zero step count");

    a_step_only_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TWR) |-> (par_cur.steps != '0 && par_cur.delay == '0))
        else $error("fade step on an idle or waiting tube");
`endif

endmodule
